FILE: hw/rtl/fpra_pkg.sv
`default_nettype none
package fpra_pkg;

    localparam int FLASH_SECTORS   = 1024;
    localparam int LOGICAL_SECTORS = 6140;
    localparam int MAP_PAGES       = 3;

    localparam int FIRST_MAP_SPAN  = 2044;
    localparam int MAP_SPAN        = 2048;

    localparam int SEC_W  = 10;
    localparam int PG_W   = 3;
    localparam int LS_W   = 13;
    localparam int ENT_W  = 16;
    localparam int ESEC_W = ENT_W - PG_W;
    localparam int MASK_W = 8;
    localparam int MP_W   = 2;
    localparam int DI_W   = (MAP_PAGES > 1) ? $clog2(MAP_PAGES) : 1;
    localparam int SA_W   = $clog2(FLASH_SECTORS);
    localparam int CLR_N  = (LOGICAL_SECTORS > FLASH_SECTORS) ? LOGICAL_SECTORS
                                                               : FLASH_SECTORS;
    localparam int CLR_W  = $clog2(CLR_N);

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_SYNC   = 2'd2;
    localparam logic [1:0] REQ_LOAD   = 2'd3;

    localparam logic [1:0] ERASE_NONE  = 2'd0;
    localparam logic [1:0] ERASE_PLAIN = 2'd1;
    localparam logic [1:0] ERASE_KEEP  = 2'd2;

    localparam logic [MASK_W-1:0] MASK_FULL = 8'hFF;

    localparam logic [2:0] K_ZERO   = 3'd0;
    localparam logic [2:0] K_LOOKUP = 3'd1;
    localparam logic [2:0] K_LOAD   = 3'd2;
    localparam logic [2:0] K_WRITE  = 3'd3;
    localparam logic [2:0] K_FULL   = 3'd4;
    localparam logic [2:0] K_SYNC   = 3'd5;

    localparam logic [1:0] UM_OLD  = 2'd0;
    localparam logic [1:0] UM_LOAD = 2'd1;
    localparam logic [1:0] UM_NEW  = 2'd2;
    localparam logic [1:0] UM_SCAN = 2'd3;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [LS_W-1:0] logical_sector;
        logic [ENT_W-1:0] load_value;
    } t_req;

    typedef struct packed {
        logic [SEC_W-1:0]  phys_sector;
        logic [PG_W-1:0]   phys_page;
        logic              mapped;
        logic [1:0]        erase_op;
        logic [MASK_W-1:0] preserve_mask;
        logic [MP_W-1:0]   map_page;
        logic              map_page_valid;
        logic              last;
        logic              status;
    } t_rsp;

    typedef struct packed {
        logic       clr_step;
        logic       cap;
        logic [1:0] um_sel;
        logic       um_wr;
        logic       um_set;
        logic       um_nz;
        logic       map_wr;
        logic       map_src_new;
        logic       cur_clear;
        logic       scan_init;
        logic       scan_step;
        logic       alloc;
        logic       out_load;
        logic [2:0] out_kind;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] req;
        logic       oor;
        logic       dirty_any;
        logic       sync_last;
        logic       need_search;
        logic       sc_done;
        logic       sc_ok;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/fpra_ctrl.sv
`default_nettype none
module fpra_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fpra_pkg::t_sts i_sts,
    output fpra_pkg::t_cmd     o_cmd
);
    import fpra_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_MAPRD   = 5'd2;
    localparam logic [4:0] S_EMIT    = 5'd3;
    localparam logic [4:0] S_SYNC    = 5'd4;
    localparam logic [4:0] S_LD_FRD  = 5'd5;
    localparam logic [4:0] S_LD_FWR  = 5'd6;
    localparam logic [4:0] S_LD_SRD  = 5'd7;
    localparam logic [4:0] S_LD_SWR  = 5'd8;
    localparam logic [4:0] S_W_FRD   = 5'd9;
    localparam logic [4:0] S_W_FWR   = 5'd10;
    localparam logic [4:0] S_SC_INIT = 5'd11;
    localparam logic [4:0] S_SC_RD   = 5'd12;
    localparam logic [4:0] S_SC_CHK  = 5'd13;
    localparam logic [4:0] S_W_ALLOC = 5'd14;
    localparam logic [4:0] S_W_SRD   = 5'd15;
    localparam logic [4:0] S_W_SWR   = 5'd16;
    localparam logic [4:0] S_W_RRD   = 5'd17;
    localparam logic [4:0] S_W_RWR   = 5'd18;

    logic [4:0] r_state, n_state;
    logic [2:0] r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_kind  <= K_ZERO;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_MAPRD;
                end
            end
            S_MAPRD: begin
                // map entry of the captured sector is valid after this cycle
                if (i_sts.req == REQ_SYNC) begin
                    if (i_sts.dirty_any) begin
                        n_state = S_SYNC;
                    end else begin
                        n_kind  = K_ZERO;
                        n_state = S_EMIT;
                    end
                end else if (i_sts.oor) begin
                    n_kind  = K_ZERO;
                    n_state = S_EMIT;
                end else if (i_sts.req == REQ_LOOKUP) begin
                    n_kind  = K_LOOKUP;
                    n_state = S_EMIT;
                end else if (i_sts.req == REQ_LOAD) begin
                    n_state = S_LD_FRD;
                end else begin
                    n_state = S_W_FRD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = r_kind;
                    n_state        = S_IDLE;
                end
            end
            S_SYNC: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = K_SYNC;
                    if (i_sts.sync_last) n_state = S_IDLE;
                end
            end
            S_LD_FRD: begin
                o_cmd.um_sel = UM_OLD;
                n_state      = S_LD_FWR;
            end
            S_LD_FWR: begin
                o_cmd.um_sel = UM_OLD;
                o_cmd.um_wr  = 1'b1;
                o_cmd.um_nz  = 1'b1;
                n_state      = S_LD_SRD;
            end
            S_LD_SRD: begin
                o_cmd.um_sel = UM_LOAD;
                n_state      = S_LD_SWR;
            end
            S_LD_SWR: begin
                o_cmd.um_sel    = UM_LOAD;
                o_cmd.um_wr     = 1'b1;
                o_cmd.um_set    = 1'b1;
                o_cmd.um_nz     = 1'b1;
                o_cmd.map_wr    = 1'b1;
                o_cmd.cur_clear = 1'b1;
                n_kind          = K_LOAD;
                n_state         = S_EMIT;
            end
            S_W_FRD: begin
                o_cmd.um_sel = UM_OLD;
                n_state      = S_W_FWR;
            end
            S_W_FWR: begin
                o_cmd.um_sel = UM_OLD;
                o_cmd.um_wr  = 1'b1;
                o_cmd.um_nz  = 1'b1;
                n_state      = i_sts.need_search ? S_SC_INIT : S_W_ALLOC;
            end
            S_SC_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SC_RD;
            end
            S_SC_RD: begin
                o_cmd.um_sel = UM_SCAN;
                n_state      = S_SC_CHK;
            end
            S_SC_CHK: begin
                o_cmd.um_sel    = UM_SCAN;
                o_cmd.scan_step = 1'b1;
                if (i_sts.sc_done) begin
                    n_state = i_sts.sc_ok ? S_W_ALLOC : S_W_RRD;
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_W_ALLOC: begin
                o_cmd.alloc       = 1'b1;
                o_cmd.map_wr      = 1'b1;
                o_cmd.map_src_new = 1'b1;
                n_state           = S_W_SRD;
            end
            S_W_SRD: begin
                o_cmd.um_sel = UM_NEW;
                n_state      = S_W_SWR;
            end
            S_W_SWR: begin
                o_cmd.um_sel = UM_NEW;
                o_cmd.um_wr  = 1'b1;
                o_cmd.um_set = 1'b1;
                n_kind       = K_WRITE;
                n_state      = S_EMIT;
            end
            S_W_RRD: begin
                o_cmd.um_sel = UM_OLD;
                n_state      = S_W_RWR;
            end
            S_W_RWR: begin
                // no free page: give the old page back
                o_cmd.um_sel = UM_OLD;
                o_cmd.um_wr  = 1'b1;
                o_cmd.um_set = 1'b1;
                o_cmd.um_nz  = 1'b1;
                n_kind       = K_FULL;
                n_state      = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fpra_dp.sv
`default_nettype none
module fpra_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fpra_pkg::t_req i_in_data,
    input  wire fpra_pkg::t_cmd i_cmd,
    output fpra_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output fpra_pkg::t_rsp      o_out_data
);
    import fpra_pkg::*;

    logic [ENT_W-1:0]  map_mem [LOGICAL_SECTORS];
    logic [MASK_W-1:0] um_mem  [FLASH_SECTORS];

    logic [1:0]        r_req;
    logic [LS_W-1:0]   r_ls;
    logic [ENT_W-1:0]  r_lv;
    logic [ENT_W-1:0]  r_map_q;
    logic [MASK_W-1:0] r_um_q;
    logic [CLR_W-1:0]  r_clr_idx;

    logic [SA_W-1:0]   r_cur;
    logic [MASK_W-1:0] r_free;
    logic [SA_W-1:0]   r_sstart;
    logic [MAP_PAGES-1:0] r_dirty;

    logic [SA_W-1:0]   r_scan_idx;
    logic [SA_W-1:0]   r_scan_cnt;
    logic              r_have_p;
    logic [SA_W-1:0]   r_p_idx;
    logic [MASK_W-1:0] r_p_mask;

    logic [1:0]        r_eop;
    logic [MASK_W-1:0] r_pmask;
    logic [PG_W-1:0]   r_pg;
    logic [ENT_W-1:0]  r_ne;

    logic              r_ov;
    t_rsp              r_out;

    // used-mask port address
    logic [ENT_W-1:0]  um_ent;
    logic [ESEC_W-1:0] um_esec;
    logic [SA_W-1:0]   um_addr;
    logic              um_inrange;
    logic [MASK_W-1:0] um_bit;
    logic [MASK_W-1:0] um_wdata;
    logic              um_we;
    logic              clr_um;
    logic              clr_map;

    always_comb begin
        case (i_cmd.um_sel)
            UM_OLD:  um_ent = r_map_q;
            UM_LOAD: um_ent = r_lv;
            UM_NEW:  um_ent = r_ne;
            default: um_ent = '0;
        endcase
        um_esec    = um_ent[ENT_W-1:PG_W];
        um_inrange = ({1'b0, um_esec} < (ESEC_W+1)'(FLASH_SECTORS));
        if (i_cmd.um_sel == UM_SCAN) begin
            um_addr    = r_scan_idx;
            um_inrange = 1'b1;
        end else begin
            um_addr = um_esec[SA_W-1:0];
        end
        um_bit   = MASK_W'(1) << um_ent[PG_W-1:0];
        um_wdata = i_cmd.um_set ? (r_um_q | um_bit) : (r_um_q & ~um_bit);
        um_we    = i_cmd.um_wr && um_inrange && (!i_cmd.um_nz || (um_ent != '0));
    end

    assign clr_um  = i_cmd.clr_step
                     && ({1'b0, r_clr_idx} < (CLR_W+1)'(FLASH_SECTORS));
    assign clr_map = i_cmd.clr_step
                     && ({1'b0, r_clr_idx} < (CLR_W+1)'(LOGICAL_SECTORS));

    // lowest free page of the current sector, page 7 when bits 0..6 are clear
    logic [PG_W-1:0]   pg_pick;
    logic [ENT_W-1:0]  ne_calc;
    always_comb begin
        pg_pick = PG_W'(7);
        for (int k = 6; k >= 0; k--) begin
            if (r_free[k]) pg_pick = PG_W'(k);
        end
        ne_calc = ENT_W'({r_cur, pg_pick});
    end

    // map storage page that holds the entry
    logic [LS_W-1:0] ls_off;
    logic [LS_W-1:0] di_full;
    always_comb begin
        ls_off = r_ls - LS_W'(FIRST_MAP_SPAN);
        if (r_ls < LS_W'(FIRST_MAP_SPAN)) begin
            di_full = '0;
        end else begin
            di_full = LS_W'(ls_off / MAP_SPAN) + LS_W'(1);
        end
    end

    // lowest dirty map page
    logic [DI_W-1:0] sync_idx;
    always_comb begin
        sync_idx = '0;
        for (int k = MAP_PAGES - 1; k >= 0; k--) begin
            if (r_dirty[k]) sync_idx = DI_W'(k);
        end
    end

    // scan decisions
    logic              sc_empty;
    logic              sc_part;
    logic              sc_pany;
    logic              sc_last;
    logic [SA_W-1:0]   sc_pidx;
    logic [MASK_W-1:0] sc_pmask;
    logic [SA_W-1:0]   scan_next;
    always_comb begin
        sc_empty  = (r_um_q == '0);
        sc_part   = (r_um_q != MASK_FULL);
        sc_pany   = r_have_p || sc_part;
        sc_last   = (r_scan_cnt == SA_W'(FLASH_SECTORS - 1));
        sc_pidx   = r_have_p ? r_p_idx : r_scan_idx;
        sc_pmask  = r_have_p ? r_p_mask : r_um_q;
        scan_next = (r_scan_idx == SA_W'(FLASH_SECTORS - 1)) ? '0
                                                             : r_scan_idx + SA_W'(1);
    end

    always_comb begin
        o_sts             = '0;
        o_sts.clr_last    = (r_clr_idx == CLR_W'(CLR_N - 1));
        o_sts.req         = r_req;
        o_sts.oor         = (r_ls >= LS_W'(LOGICAL_SECTORS));
        o_sts.dirty_any   = (r_dirty != '0);
        o_sts.sync_last   = ((r_dirty & (r_dirty - MAP_PAGES'(1))) == '0);
        o_sts.need_search = (r_cur == '0) || (r_free == '0);
        o_sts.sc_done     = sc_empty || sc_last;
        o_sts.sc_ok       = sc_empty || sc_pany;
        o_sts.out_free    = !r_ov || i_out_ready;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (clr_map) begin
            map_mem[r_clr_idx] <= '0;
        end else if (i_cmd.map_wr) begin
            map_mem[r_ls] <= i_cmd.map_src_new ? ne_calc : r_lv;
        end
        r_map_q <= map_mem[r_ls];
    end

    always_ff @(posedge i_clk) begin
        if (clr_um) begin
            um_mem[r_clr_idx[SA_W-1:0]] <=
                ({1'b0, r_clr_idx} < (CLR_W+1)'(MAP_PAGES)) ? MASK_FULL : '0;
        end else if (um_we) begin
            um_mem[um_addr] <= um_wdata;
        end
        r_um_q <= um_mem[um_addr];
    end

    // request payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_ls    <= i_in_data.logical_sector;
            r_lv    <= i_in_data.load_value;
            r_eop   <= ERASE_NONE;
            r_pmask <= '0;
        end
        if (i_cmd.scan_init) begin
            r_scan_idx <= r_sstart;
            r_scan_cnt <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= scan_next;
            r_scan_cnt <= r_scan_cnt + SA_W'(1);
            if (!r_have_p && sc_part) begin
                r_p_idx  <= r_scan_idx;
                r_p_mask <= r_um_q;
            end
            if (!sc_empty && sc_last && sc_pany) begin
                r_eop   <= ERASE_KEEP;
                r_pmask <= sc_pmask;
            end else if (sc_empty) begin
                r_eop <= ERASE_PLAIN;
            end
        end
        if (i_cmd.alloc) begin
            r_pg <= pg_pick;
            r_ne <= ne_calc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req     <= REQ_WRITE;
            r_clr_idx <= '0;
            r_cur     <= '0;
            r_free    <= '0;
            r_sstart  <= '0;
            r_dirty   <= '0;
            r_have_p  <= 1'b0;
        end else begin
            if (i_cmd.cap) r_req <= i_in_data.req_type;
            if (i_cmd.clr_step) r_clr_idx <= r_clr_idx + CLR_W'(1);
            if (i_cmd.cur_clear) r_cur <= '0;
            if (i_cmd.scan_init) begin
                r_have_p <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (sc_part) r_have_p <= 1'b1;
                if (sc_empty) begin
                    r_cur    <= r_scan_idx;
                    r_free   <= MASK_FULL;
                    r_sstart <= r_scan_idx;
                end else if (sc_last && sc_pany) begin
                    r_cur    <= sc_pidx;
                    r_free   <= ~sc_pmask;
                    r_sstart <= sc_pidx;
                end
            end
            if (i_cmd.alloc) begin
                r_free <= r_free & ~(MASK_W'(1) << pg_pick);
                if (di_full < LS_W'(MAP_PAGES)) r_dirty[di_full[DI_W-1:0]] <= 1'b1;
            end
            if (i_cmd.out_load && (i_cmd.out_kind == K_SYNC)) begin
                r_dirty[sync_idx] <= 1'b0;
            end
        end
    end

    // output register
    t_rsp rsp_next;
    always_comb begin
        rsp_next      = '0;
        rsp_next.last = 1'b1;
        case (i_cmd.out_kind)
            K_LOOKUP: begin
                if (r_map_q != '0) begin
                    rsp_next.phys_sector = r_map_q[SEC_W+PG_W-1:PG_W];
                    rsp_next.phys_page   = r_map_q[PG_W-1:0];
                    rsp_next.mapped      = 1'b1;
                end
            end
            K_LOAD: begin
                if (r_lv != '0) begin
                    rsp_next.phys_sector = r_lv[SEC_W+PG_W-1:PG_W];
                    rsp_next.phys_page   = r_lv[PG_W-1:0];
                    rsp_next.mapped      = 1'b1;
                end
            end
            K_WRITE: begin
                rsp_next.phys_sector   = SEC_W'(r_cur);
                rsp_next.phys_page     = r_pg;
                rsp_next.mapped        = 1'b1;
                rsp_next.erase_op      = r_eop;
                rsp_next.preserve_mask = r_pmask;
            end
            K_FULL: begin
                rsp_next.status = 1'b1;
            end
            K_SYNC: begin
                rsp_next.map_page       = MP_W'(sync_idx);
                rsp_next.map_page_valid = 1'b1;
                rsp_next.last           = o_sts.sync_last;
            end
            default: begin
                rsp_next.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out <= rsp_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: hw/rtl/flash_page_remap_allocator_top.sv
`default_nettype none
// channel | valid      | ready       | word
// request | i_in_valid | o_in_ready  | i_in_data  (req_type, logical_sector, load_value)
// result  | o_out_valid| i_out_ready | o_out_data (page, erase, sync and status fields)
//
// after reset the map and used-mask memories are swept, one entry a cycle, over every
// map entry; no request is taken until the sweep ends
// lookup and out-of-range read the map and emit; load and write update used masks first
// a sector search reads one used mask per read-and-check step from the single mask port,
// so a write that searches checks up to 1024 sectors
// a sync gives one word a cycle per dirty map page, but a stalled result holds the block
module flash_page_remap_allocator_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire fpra_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output fpra_pkg::t_rsp      o_out_data
);
    import fpra_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fpra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_full_unmapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> !o_out_data.mapped && o_out_data.last)
        else $error("full result carries a page");

    a_mask_only_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.erase_op != ERASE_KEEP)
        |-> (o_out_data.preserve_mask == '0))
        else $error("preserve mask without keeping erase");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

endmodule
`default_nettype wire

FILE: bench/fpra_checker.sv
`timescale 1ns / 1ps
module fpra_checker
    import fpra_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ready,
    input  wire t_req i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_ready,
    input  wire t_rsp i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_word_count
);

    logic [ENT_W-1:0]  map_entry [LOGICAL_SECTORS];
    logic [MASK_W-1:0] used_mask [FLASH_SECTORS];
    logic              dirty [MAP_PAGES];
    int                cur_sec;
    logic [MASK_W-1:0] cur_free;
    int                scan_base;
    t_rsp              expected_words [$];

    function automatic t_rsp blank_word();
        t_rsp w;
        w = '0;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic void mark_page(logic [ENT_W-1:0] e, logic used);
        int s;
        s = int'(e >> 3);
        if (s < FLASH_SECTORS) begin
            if (used) used_mask[s][e[2:0]] = 1'b1;
            else used_mask[s][e[2:0]] = 1'b0;
        end
    endfunction

    function automatic int scan_sectors(logic want_empty);
        int idx;
        for (int i = 0; i < FLASH_SECTORS; i++) begin
            idx = (i + scan_base) % FLASH_SECTORS;
            if (want_empty ? (used_mask[idx] == '0) : (used_mask[idx] != MASK_FULL))
                return idx;
        end
        return -1;
    endfunction

    function automatic void reset_state();
        for (int i = 0; i < LOGICAL_SECTORS; i++) map_entry[i] = '0;
        for (int i = 0; i < FLASH_SECTORS; i++)
            used_mask[i] = (i < MAP_PAGES) ? MASK_FULL : '0;
        for (int i = 0; i < MAP_PAGES; i++) dirty[i] = 1'b0;
        cur_sec = 0;
        cur_free = '0;
        scan_base = 0;
        expected_words.delete();
    endfunction

    function automatic void predict_request(t_req r);
        t_rsp w;
        int ls, found, pg, di, n;
        logic [ENT_W-1:0] old_e, new_e;
        logic [1:0] eop;
        logic [MASK_W-1:0] pm;
        ls = int'(r.logical_sector);
        w = '0;
        if (r.req_type == REQ_SYNC) begin
            n = 0;
            for (int i = 0; i < MAP_PAGES; i++) begin
                if (dirty[i]) begin
                    dirty[i] = 1'b0;
                    w = '0;
                    w.map_page = MP_W'(i);
                    w.map_page_valid = 1'b1;
                    expected_words.push_back(w);
                    n++;
                end
            end
            if (n == 0) expected_words.push_back(blank_word());
            else expected_words[$].last = 1'b1;
            return;
        end
        if (ls >= LOGICAL_SECTORS) begin
            expected_words.push_back(blank_word());
            return;
        end
        if (r.req_type == REQ_LOOKUP) begin
            w = blank_word();
            if (map_entry[ls] != 0) begin
                w.phys_sector = SEC_W'(map_entry[ls] >> 3);
                w.phys_page = map_entry[ls][2:0];
                w.mapped = 1'b1;
            end
            expected_words.push_back(w);
            return;
        end
        if (r.req_type == REQ_LOAD) begin
            if (map_entry[ls] != 0) mark_page(map_entry[ls], 1'b0);
            map_entry[ls] = r.load_value;
            w = blank_word();
            if (r.load_value != 0) begin
                mark_page(r.load_value, 1'b1);
                w.phys_sector = SEC_W'(r.load_value >> 3);
                w.phys_page = r.load_value[2:0];
                w.mapped = 1'b1;
            end
            cur_sec = 0;
            expected_words.push_back(w);
            return;
        end
        // write remap
        old_e = map_entry[ls];
        eop = ERASE_NONE;
        pm = '0;
        if (old_e != 0) mark_page(old_e, 1'b0);
        if (cur_sec == 0 || cur_free == 0) begin
            found = scan_sectors(1'b1);
            if (found >= 0) begin
                cur_sec = found;
                cur_free = MASK_FULL;
                eop = ERASE_PLAIN;
            end else begin
                found = scan_sectors(1'b0);
                if (found >= 0) begin
                    cur_sec = found;
                    pm = used_mask[found];
                    cur_free = ~used_mask[found];
                    eop = ERASE_KEEP;
                end else begin
                    if (old_e != 0) mark_page(old_e, 1'b1);
                    w = blank_word();
                    w.status = 1'b1;
                    expected_words.push_back(w);
                    return;
                end
            end
            scan_base = found;
        end
        for (pg = 0; pg < 7; pg++) if (cur_free[pg]) break;
        cur_free[pg] = 1'b0;
        new_e = ENT_W'((cur_sec << 3) | pg);
        map_entry[ls] = new_e;
        di = (ls < FIRST_MAP_SPAN) ? 0 : 1 + (ls - FIRST_MAP_SPAN) / MAP_SPAN;
        if (di < MAP_PAGES) dirty[di] = 1'b1;
        mark_page(new_e, 1'b1);
        w = blank_word();
        w.phys_sector = SEC_W'(cur_sec);
        w.phys_page = PG_W'(pg);
        w.mapped = 1'b1;
        w.erase_op = eop;
        w.preserve_mask = pm;
        expected_words.push_back(w);
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
            o_fail_count <= 0;
            o_word_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) predict_request(i_in_data);
            if (i_out_valid && i_out_ready) begin
                o_word_count <= o_word_count + 1;
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected word %p at %0t", i_out_data, $realtime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (i_out_data !== expected_words[0]) begin
                        if (o_fail_count < 10)
                            $display("word mismatch at %0t: expected %p, got %p",
                                     $realtime, expected_words[0], i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(expected_words.pop_front());
                end
            end
        end
    end

endmodule

FILE: bench/tb_flash_page_remap_allocator_top.sv
`timescale 1ns / 1ps
module tb_flash_page_remap_allocator_top;
    import fpra_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_req in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp out_data;
    int   fail_count, pending, word_count;
    logic quiet = 1'b0;
    int   req_count = 0;

    always #6 i_clk = ~i_clk;

    flash_page_remap_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    fpra_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_word_count(word_count)
    );

    always @(posedge i_clk) begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
    end

    // valid stays up after an accept until the next word or an idle cycle replaces it
    task automatic send_req(logic [1:0] kind, logic [LS_W-1:0] ls, logic [ENT_W-1:0] lv);
        t_req r;
        r.req_type = kind;
        r.logical_sector = ls;
        r.load_value = lv;
        while (!quiet && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        req_count++;
    endtask

    function automatic logic [LS_W-1:0] pick_sector();
        int c;
        c = $urandom_range(99);
        if (c < 70) return LS_W'($urandom_range(40));
        if (c < 90) return LS_W'($urandom_range(LOGICAL_SECTORS - 1));
        if (c < 95) return LS_W'($urandom_range(8191, LOGICAL_SECTORS));
        return LS_W'(LOGICAL_SECTORS - 1 - $urandom_range(3));
    endfunction

    // keeps loaded entries on devices sectors mostly, sometimes beyond the device
    function automatic logic [ENT_W-1:0] pick_entry();
        int c;
        c = $urandom_range(99);
        if (c < 10) return '0;
        if (c < 20) return ENT_W'($urandom_range(16'hFFFF));
        return ENT_W'($urandom_range(FLASH_SECTORS * 8 - 1));
    endfunction

    initial begin
        int c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, every request type and the corner cases
        send_req(REQ_SYNC, 0, 0);
        send_req(REQ_LOOKUP, 0, 0);
        send_req(REQ_WRITE, 0, 0);
        send_req(REQ_WRITE, 0, 16'hFFFF);
        send_req(REQ_WRITE, FIRST_MAP_SPAN, 0);
        send_req(REQ_WRITE, LOGICAL_SECTORS - 1, 0);
        send_req(REQ_LOOKUP, 0, 0);
        send_req(REQ_WRITE, 13'h1FFF, 16'hFFFF);
        send_req(REQ_LOOKUP, LOGICAL_SECTORS, 0);
        send_req(REQ_LOAD, 13'h1FFF, 16'hFFFF);
        send_req(REQ_LOAD, 5, 16'hFFFF);
        send_req(REQ_LOOKUP, 5, 0);
        send_req(REQ_LOAD, 5, 16'h0000);
        send_req(REQ_LOAD, 0, 16'h0003);
        send_req(REQ_LOAD, 6, 16'h0009);
        send_req(REQ_WRITE, 6, 0);
        send_req(REQ_SYNC, 0, 0);
        send_req(REQ_SYNC, 0, 0);
        send_req(REQ_LOAD, 7, 16'h5555);
        send_req(REQ_LOAD, 8, 16'h2AAA);
        send_req(REQ_LOOKUP, 8, 0);
        // random, with a quiet stretch in the middle
        for (int i = 0; i < 260; i++) begin
            quiet = (i >= 120 && i < 170);
            c = $urandom_range(99);
            if (c < 50) send_req(REQ_WRITE, pick_sector(), ENT_W'($urandom));
            else if (c < 70) send_req(REQ_LOOKUP, pick_sector(), ENT_W'($urandom));
            else if (c < 82) send_req(REQ_SYNC, LS_W'($urandom), ENT_W'($urandom));
            else send_req(REQ_LOAD, pick_sector(), pick_entry());
        end
        in_valid <= 1'b0;
        quiet = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (2200) @(posedge i_clk);
        $display("%0d requests sent, %0d result words checked", req_count, word_count);
        $display("covered writes, lookups, syncs and loads incl. out-of-range sectors");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
